[rtl/rcp_pkg.sv]
// Package for the readable color picker: beat types, constants and lookup tables.
`default_nettype none

package rcp_pkg;

  // Fraction bits of the linear-light values
  localparam int unsigned LUMA_FRACTION_BITS = 16;
  localparam int unsigned LIN_W  = LUMA_FRACTION_BITS + 1;   // 0 .. 1.0
  localparam int unsigned LUMA_W = LUMA_FRACTION_BITS + 17;  // 0 .. 1.0 in Q(F+16)
  localparam int unsigned AB_W   = LUMA_FRACTION_BITS + 21;  // 20*L + 1.0 <= 21.0
  localparam int unsigned RATIO_W = 13;
  localparam int unsigned PROD_W = AB_W + RATIO_W;

  // Luminance weights in Q16, they sum to 1.0
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // 1.0 in the luminance scale
  localparam logic [AB_W-1:0] LUMA_ONE = AB_W'(1) << (LUMA_FRACTION_BITS + 16);

  typedef enum logic [1:0] {
    CHOICE_PREFERRED = 2'd0,
    CHOICE_WHITE     = 2'd1,
    CHOICE_BLACK     = 2'd2,
    CHOICE_FALLBACK  = 2'd3
  } choice_e;

  typedef struct packed {
    logic [7:0]         preferred_red;
    logic [7:0]         preferred_green;
    logic [7:0]         preferred_blue;
    logic [7:0]         back_red;
    logic [7:0]         back_green;
    logic [7:0]         back_blue;
    logic [RATIO_W-1:0] min_ratio_q8;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    choice_e    choice;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Load enables of the two luminance stages
  typedef struct packed {
    logic lin_en;
    logic luma_en;
  } luma_ctrl_t;

  typedef logic [LIN_W-1:0] lin_rom_t [256];
  typedef logic [7:0]       byte_rom_t [256];

  // Q30 product rounded half up
  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b + 64'd536870912;
    return p >> 30;
  endfunction

  function automatic logic [63:0] pow5_q30(logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = mul_q30(y, y);
    y4 = mul_q30(y2, y2);
    return mul_q30(y4, y);
  endfunction

  // sRGB code to linear light in Q(F), evaluated at elaboration only
  function automatic logic [63:0] srgb_linear(logic [63:0] c);
    logic [63:0] u;
    logic [63:0] w;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lin30;
    if (c <= 64'd10) begin
      return (((c * 64'd5) << LUMA_FRACTION_BITS) + 64'd8236) / 64'd16473;
    end
    u = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    w = mul_q30(u, u);
    lo = 64'd0;
    hi = (64'd1 << 30) + 64'd1;
    for (int k = 0; k < 40; k++) begin
      if (hi - lo > 64'd1) begin
        mid = (lo + hi) >> 1;
        if (pow5_q30(mid) <= w) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    lin30 = mul_q30(w, lo);
    return (lin30 + (64'd1 << (29 - LUMA_FRACTION_BITS))) >> (30 - LUMA_FRACTION_BITS);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int c = 0; c < 256; c++) begin
      rom[c] = LIN_W'(srgb_linear(64'(c)));
    end
    return rom;
  endfunction

  // Mix 72% toward white or black, rounded to nearest
  function automatic byte_rom_t build_mix_rom(logic lighten);
    byte_rom_t rom;
    int unsigned bias;
    bias = lighten ? 18410 : 50;
    for (int x = 0; x < 256; x++) begin
      rom[x] = 8'((28 * x + bias) / 100);
    end
    return rom;
  endfunction

  // Smallest background luminance for which black contrasts at least as much as white:
  // (20*L + 1)^2 >= 21, solved exactly with integers
  function automatic logic [LUMA_W-1:0] build_black_min();
    logic [127:0] s;
    logic [127:0] lim;
    logic [127:0] lo;
    logic [127:0] hi;
    logic [127:0] mid;
    s = 128'd1 << (LUMA_FRACTION_BITS + 16);
    lim = 128'd21 * s * s;
    lo = 128'd0;
    hi = s * 128'd5;
    for (int k = 0; k < 64; k++) begin
      if (hi - lo > 128'd1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid >= lim) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
    end
    return LUMA_W'((hi - s + 128'd19) / 128'd20);
  endfunction

  localparam lin_rom_t  LIN_ROM       = build_lin_rom();
  localparam byte_rom_t MIX_WHITE_ROM = build_mix_rom(1'b1);
  localparam byte_rom_t MIX_BLACK_ROM = build_mix_rom(1'b0);
  localparam logic [LUMA_W-1:0] BLACK_MIN = build_black_min();

endpackage

`default_nettype wire

[rtl/rcp_luma.sv]
// Two-stage relative luminance of one RGB888 color: linear lookup, then weighted sum.
`default_nettype none

module rcp_luma (
  input  wire                       clk_i,
  input  rcp_pkg::luma_ctrl_t       ctrl_i,
  input  rcp_pkg::rgb_t             color_i,
  output logic [rcp_pkg::LUMA_W-1:0] luma_o
);
  import rcp_pkg::*;

  logic [LIN_W-1:0]  lin_r_q, lin_g_q, lin_b_q;
  logic [LUMA_W-1:0] luma_d, luma_q;

  // Look up linear light per channel
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lin_en) begin
      lin_r_q <= LIN_ROM[color_i.red];
      lin_g_q <= LIN_ROM[color_i.green];
      lin_b_q <= LIN_ROM[color_i.blue];
    end
  end

  // Weight and sum, exact in Q(F+16)
  always_comb begin
    luma_d = LUMA_W'(lin_r_q) * LUMA_W'(COEF_R)
           + LUMA_W'(lin_g_q) * LUMA_W'(COEF_G)
           + LUMA_W'(lin_b_q) * LUMA_W'(COEF_B);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.luma_en) begin
      luma_q <= luma_d;
    end
  end

  assign luma_o = luma_q;

endmodule

`default_nettype wire

[rtl/readable_color_pick.sv]
// Top level of the readable color picker: six-stage pipeline with valid/ready beats.
//
// Input channel: in_valid_i / in_ready_o carry one in_beat_t per beat: a preferred
// color, a background color and a minimum contrast ratio in Q8. Output channel:
// out_valid_o / out_ready_i carry one out_beat_t per input beat, in order: the
// first of preferred, 72% toward white, 72% toward black that reaches the ratio
// against the background, else black or white, whichever contrasts more.
//
// Throughput is one beat per cycle when the receiver does not stall; each of the six
// register stages (mix lookup, linear lookup, luminance sum, contrast terms, ratio
// products, compare and select) holds one item.
//
// Reset clears every stage valid bit; the pipeline comes out of reset empty.
// When the receiver stalls, the output stage holds its beat and each stage below
// holds only if the stage above it is full, so bubbles close up and input keeps
// being taken until every stage is occupied. Nothing is dropped or repeated.
`default_nettype none

module readable_color_pick (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  rcp_pkg::in_beat_t    in_beat_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output rcp_pkg::out_beat_t   out_beat_o
);
  import rcp_pkg::*;

  localparam int unsigned NS = 6;

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  rgb_t               col_q   [5][3];
  rgb_t               bg_q;
  logic [RATIO_W-1:0] ratio_q [4];
  logic [LUMA_W-1:0]  luma    [4];
  logic [AB_W-1:0]    a_q     [3];
  logic [AB_W-1:0]    b_q     [3];
  logic [PROD_W-1:0]  lhs_q   [3];
  logic [PROD_W-1:0]  rhs_q   [3];
  logic               black_q [2];
  logic [2:0]         pass;
  out_beat_t          out_d, out_q;
  luma_ctrl_t         luma_ctrl;

  // Stage ready chain: a stage may load when empty or when the next one loads
  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: form the candidates and capture the background
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      col_q[0][0] <= '{in_beat_i.preferred_red, in_beat_i.preferred_green,
                       in_beat_i.preferred_blue};
      col_q[0][1] <= '{MIX_WHITE_ROM[in_beat_i.preferred_red],
                       MIX_WHITE_ROM[in_beat_i.preferred_green],
                       MIX_WHITE_ROM[in_beat_i.preferred_blue]};
      col_q[0][2] <= '{MIX_BLACK_ROM[in_beat_i.preferred_red],
                       MIX_BLACK_ROM[in_beat_i.preferred_green],
                       MIX_BLACK_ROM[in_beat_i.preferred_blue]};
      bg_q        <= '{in_beat_i.back_red, in_beat_i.back_green, in_beat_i.back_blue};
      ratio_q[0]  <= in_beat_i.min_ratio_q8;
    end
  end

  // Carry candidate colors and ratio down the pipe
  always_ff @(posedge clk_i) begin
    for (int k = 1; k < 5; k++) begin
      if (rdy[k]) begin
        col_q[k] <= col_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        ratio_q[k] <= ratio_q[k-1];
      end
    end
  end

  // Stages 1 and 2: luminance of the three candidates and the background
  assign luma_ctrl = '{lin_en: rdy[1], luma_en: rdy[2]};

  for (genvar i = 0; i < 3; i++) begin : g_luma
    rcp_luma u_luma (
      .clk_i   (clk_i),
      .ctrl_i  (luma_ctrl),
      .color_i (col_q[0][i]),
      .luma_o  (luma[i])
    );
  end

  rcp_luma u_luma_bg (
    .clk_i   (clk_i),
    .ctrl_i  (luma_ctrl),
    .color_i (bg_q),
    .luma_o  (luma[3])
  );

  // Stage 3: contrast terms 20*L + 1 for the lighter and darker side, and the black flag
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        if (luma[i] > luma[3]) begin
          a_q[i] <= AB_W'(luma[i]) * AB_W'(20) + LUMA_ONE;
          b_q[i] <= AB_W'(luma[3]) * AB_W'(20) + LUMA_ONE;
        end else begin
          a_q[i] <= AB_W'(luma[3]) * AB_W'(20) + LUMA_ONE;
          b_q[i] <= AB_W'(luma[i]) * AB_W'(20) + LUMA_ONE;
        end
      end
      black_q[0] <= (luma[3] >= BLACK_MIN);
    end
  end

  // Stage 4: cross-multiplied ratio test operands
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        lhs_q[i] <= PROD_W'(a_q[i]) << 8;
        rhs_q[i] <= PROD_W'(ratio_q[3]) * PROD_W'(b_q[i]);
      end
      black_q[1] <= black_q[0];
    end
  end

  // Stage 5: take the first passing candidate, else the better of black and white
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pass[i] = (lhs_q[i] >= rhs_q[i]);
    end
    if (pass[0]) begin
      out_d = '{col_q[4][0].red, col_q[4][0].green, col_q[4][0].blue, CHOICE_PREFERRED};
    end else if (pass[1]) begin
      out_d = '{col_q[4][1].red, col_q[4][1].green, col_q[4][1].blue, CHOICE_WHITE};
    end else if (pass[2]) begin
      out_d = '{col_q[4][2].red, col_q[4][2].green, col_q[4][2].blue, CHOICE_BLACK};
    end else if (black_q[1]) begin
      out_d = '{8'h00, 8'h00, 8'h00, CHOICE_FALLBACK};
    end else begin
      out_d = '{8'hff, 8'hff, 8'hff, CHOICE_FALLBACK};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

[tb/tb_readable_color_pick.sv]
// Testbench for readable_color_pick: directed and random color jobs checked against a predictor.
`default_nettype none

module tb_readable_color_pick;
  timeunit 1ns;
  timeprecision 1ps;

  import rcp_pkg::*;

  localparam int unsigned FB         = LUMA_FRACTION_BITS;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 80;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  in_beat_t  in_beat  = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  logic [63:0]  lin_table [256];
  out_beat_t    expected_colors [$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_cycles = 0;

  readable_color_pick dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q30 product, rounded half up
  function automatic logic [63:0] q30_round_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] fifth_power(logic [63:0] y);
    logic [63:0] sq;
    sq = q30_round_mul(y, y);
    return q30_round_mul(q30_round_mul(sq, sq), y);
  endfunction

  // sRGB code to linear light in Q(FB): linear segment, else ((c+0.055)/1.055)^2.4
  function automatic logic [63:0] linear_light(int unsigned code);
    logic [63:0] c;
    logic [63:0] base;
    logic [63:0] base_sq;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lin30;
    c = 64'(code);
    if (c <= 64'd10) begin
      return (((c * 64'd5) << FB) + 64'd8236) / 64'd16473;
    end
    base = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    base_sq = q30_round_mul(base, base);
    // largest fifth root not above base^2, so that base^2 * root = base^2.4
    lo = 64'd0;
    hi = (64'd1 << 30) + 64'd1;
    while (hi - lo > 64'd1) begin
      mid = (lo + hi) >> 1;
      if (fifth_power(mid) <= base_sq) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    lin30 = q30_round_mul(base_sq, lo);
    return (lin30 + (64'd1 << (29 - FB))) >> (30 - FB);
  endfunction

  function automatic logic [63:0] rel_luminance(rgb_t c);
    return 64'(COEF_R) * lin_table[c.red] + 64'(COEF_G) * lin_table[c.green]
         + 64'(COEF_B) * lin_table[c.blue];
  endfunction

  // Cross-multiplied WCAG test: (Lh + 0.05) / (Ll + 0.05) >= ratio
  function automatic logic contrast_ok(logic [63:0] la, logic [63:0] lb,
                                       logic [RATIO_W-1:0] ratio);
    logic [63:0] one;
    logic [63:0] lum_hi;
    logic [63:0] lum_lo;
    one = 64'd1 << (FB + 16);
    lum_hi = (la > lb) ? la : lb;
    lum_lo = (la > lb) ? lb : la;
    return 64'd256 * (64'd20 * lum_hi + one) >= 64'(ratio) * (64'd20 * lum_lo + one);
  endfunction

  // Black wins when (20*L + 1)^2 >= 21, ties included
  function automatic logic black_beats_white(logic [63:0] lbg);
    logic [127:0] one;
    logic [127:0] x;
    one = 128'd1 << (FB + 16);
    x = 128'd20 * 128'(lbg) + one;
    return x * x >= 128'd21 * one * one;
  endfunction

  function automatic rgb_t mix_color(rgb_t c, logic to_white);
    int unsigned bias;
    rgb_t m;
    bias = to_white ? 18410 : 50;
    m.red   = 8'((28 * int'(c.red) + bias) / 100);
    m.green = 8'((28 * int'(c.green) + bias) / 100);
    m.blue  = 8'((28 * int'(c.blue) + bias) / 100);
    return m;
  endfunction

  function automatic out_beat_t pick_readable(in_beat_t job);
    rgb_t        pref;
    rgb_t        back;
    rgb_t        cand;
    logic [63:0] lbg;
    choice_e     pick;
    pref = '{job.preferred_red, job.preferred_green, job.preferred_blue};
    back = '{job.back_red, job.back_green, job.back_blue};
    lbg = rel_luminance(back);
    cand = pref;
    pick = CHOICE_PREFERRED;
    if (!contrast_ok(rel_luminance(cand), lbg, job.min_ratio_q8)) begin
      cand = mix_color(pref, 1'b1);
      pick = CHOICE_WHITE;
      if (!contrast_ok(rel_luminance(cand), lbg, job.min_ratio_q8)) begin
        cand = mix_color(pref, 1'b0);
        pick = CHOICE_BLACK;
        if (!contrast_ok(rel_luminance(cand), lbg, job.min_ratio_q8)) begin
          cand = black_beats_white(lbg) ? '{8'd0, 8'd0, 8'd0} : '{8'd255, 8'd255, 8'd255};
          pick = CHOICE_FALLBACK;
        end
      end
    end
    return '{cand.red, cand.green, cand.blue, pick};
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic in_beat_t color_job(int pr, int pg, int pb, int br, int bg, int bb,
                                         int ratio);
    return '{8'(pr), 8'(pg), 8'(pb), 8'(br), 8'(bg), 8'(bb), RATIO_W'(ratio)};
  endfunction

  // Offer one beat and hold it until taken, then record what should come out
  task automatic send_color_job(input in_beat_t job);
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= job;
    do @(posedge clk); while (!in_ready);
    expected_colors.push_back(pick_readable(job));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_beat_t random_color_job();
    in_beat_t job;
    int       gray;
    job.preferred_red   = random_channel();
    job.preferred_green = random_channel();
    job.preferred_blue  = random_channel();
    job.back_red        = random_channel();
    job.back_green      = random_channel();
    job.back_blue       = random_channel();
    // now and then a gray background near the black/white crossover
    if ($urandom_range(0, 9) == 0) begin
      gray = $urandom_range(105, 130);
      job.back_red   = 8'(gray);
      job.back_green = 8'(gray);
      job.back_blue  = 8'(gray);
    end
    case ($urandom_range(0, 9))
      0:       job.min_ratio_q8 = RATIO_W'($urandom_range(0, 8191));
      1:       job.min_ratio_q8 = RATIO_W'($urandom_range(5300, 5400));
      2:       job.min_ratio_q8 = RATIO_W'($urandom_range(0, 300));
      default: job.min_ratio_q8 = RATIO_W'($urandom_range(256, 2048));
    endcase
    return job;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Black and white at the ratio limits, ratios below 1.0 and above 21.0
  task automatic test_extremes();
    send_color_job(color_job(0, 0, 0, 255, 255, 255, 5376));
    send_color_job(color_job(255, 255, 255, 0, 0, 0, 5376));
    send_color_job(color_job(255, 255, 255, 0, 0, 0, 5377));
    send_color_job(color_job(0, 0, 0, 255, 255, 255, 8191));
    send_color_job(color_job(128, 128, 128, 128, 128, 128, 0));
    send_color_job(color_job(200, 10, 90, 200, 10, 90, 255));
    send_color_job(color_job(200, 10, 90, 200, 10, 90, 256));
    send_color_job(color_job(255, 0, 0, 0, 0, 255, 1792));
    send_color_job(color_job(0, 255, 0, 255, 0, 255, 1152));
  endtask

  // One job landing on each of the four choices
  task automatic test_each_choice();
    send_color_job(color_job(255, 255, 255, 0, 0, 0, 1152));
    send_color_job(color_job(100, 100, 100, 0, 0, 0, 1792));
    send_color_job(color_job(150, 150, 150, 255, 255, 255, 1792));
    send_color_job(color_job(120, 60, 200, 118, 118, 118, 1792));
  endtask

  // Gray backgrounds around the point where black and white contrast equally
  task automatic test_fallback_crossover();
    for (int g = 114; g <= 122; g++) begin
      send_color_job(color_job(g, g, g, g, g, g, 8191));
    end
  endtask

  // Bursts of random jobs with random gaps, some stretches back to back
  task automatic test_random_stream(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_color_job(random_color_job());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 6));
      end
    end
  endtask

  // Receiver holds off for a long stretch while jobs keep coming
  task automatic test_backpressure();
    hold_cycles = LONG_HOLD;
    for (int k = 0; k < 30; k++) begin
      send_color_job(random_color_job());
    end
    idle_sender(2);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Stall on a pattern of changing runs; a long hold takes precedence
  initial begin
    rx_mode_e    mode;
    int unsigned run_left;
    mode = RX_STEADY;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else begin
        if (run_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          run_left = $urandom_range(8, 64);
        end
        run_left--;
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
          default:   out_ready <= (run_left % 3 == 0);
        endcase
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        $error("result beat with nothing expected: %p", out_beat);
        mismatch_count++;
      end else begin
        want = expected_colors.pop_front();
        if (out_beat.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, out_beat.out_red);
          mismatch_count++;
        end
        if (out_beat.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, out_beat.out_green);
          mismatch_count++;
        end
        if (out_beat.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, out_beat.out_blue);
          mismatch_count++;
        end
        if (out_beat.choice !== want.choice) begin
          $error("choice: expected %0d, got %0d", want.choice, out_beat.choice);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int c = 0; c < 256; c++) begin
      lin_table[c] = linear_light(c);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_each_choice();
    test_fallback_crossover();
    test_random_stream(470);
    test_backpressure();

    // drain, then allow the pipeline depth for stray beats
    idle_sender(0);
    wait (expected_colors.size() == 0);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/rcp_pkg.sv
rtl/rcp_luma.sv
rtl/readable_color_pick.sv
tb/tb_readable_color_pick.sv
